>>> src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the single touch tracker
// Command codes, event kinds, point and event words, queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_POINTS  = 5;

	localparam int ID_W    = 4;
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 16;
	localparam int ESIZE_W = 15;
	localparam int WAIT_W  = 5;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FPC_W = $clog2(MAX_POINTS + 2);

	localparam logic [SIZE_W-1:0] SIZE_LIMIT = 16'd32767;

	typedef enum logic [1:0] {
		CMD_POINT = 2'd0,
		CMD_EMPTY = 2'd1,
		CMD_POP   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DOWN = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_UP   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIZE_W-1:0]  size;
	} point_t;

	// one decoded input word as it travels from front to back
	typedef struct packed {
		cmd_t   cmd;
		point_t pt;
		logic   last;
	} op_t;

	// one queued event word
	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ESIZE_W-1:0] size;
	} event_t;

	// request from the tracker to the event queue for one cycle
	typedef struct packed {
		logic   a_valid;
		event_t a;
		logic   b_valid;
		event_t b;
		logic   pop;
		logic   clear;
	} evq_req_t;

endpackage

`default_nettype wire

>>> src/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: input side of the single touch tracker
// Accepts input words, decodes the command and holds them in a two-entry
// queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front
	import stt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [ID_W-1:0]    point_id,
	input  wire logic [COORD_W-1:0] point_x,
	input  wire logic [COORD_W-1:0] point_y,
	input  wire logic [SIZE_W-1:0]  point_size,
	input  wire logic               last_in_frame,
	output logic                    op_valid,
	output op_t                     op,
	input  wire logic               op_take
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        op_in;

	// decode the incoming word
	always_comb begin
		op_in.cmd     = cmd_t'(cmd);
		op_in.pt.id   = point_id;
		op_in.pt.x    = point_x;
		op_in.pt.y    = point_y;
		op_in.pt.size = point_size;
		op_in.last    = last_in_frame;
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign op_valid   = (cnt_q != 2'd0);
	assign op         = slot_q[rd_ptr_q];

	// hold decoded words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q[0] <= '0;
			slot_q[1] <= '0;
		end else if (push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (op_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, op_take};
		end
	end

endmodule

`default_nettype wire

>>> src/stt_track.sv
// ----------------------------------------------------------------------------
// stt_track: contact tracking state of the single touch tracker
// Collects the points of a frame, picks the tracked point at frame end and
// issues down, move and up events, pops and clears to the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_track
	import stt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  wire op_t  op,
	output logic      op_take,
	input  wire logic pop_ready,
	output evq_req_t  req
);

	localparam logic [FPC_W-1:0] MAX_FPC = FPC_W'(MAX_POINTS);

	logic               pressed_q;
	logic [ID_W-1:0]    tracked_q;
	logic [COORD_W-1:0] last_x_q;
	logic [COORD_W-1:0] last_y_q;
	logic [SIZE_W-1:0]  last_size_q;
	logic [FPC_W-1:0]   fpc_q;
	point_t             chosen_q;
	logic               match_q;

	logic               pressed_n;
	logic [ID_W-1:0]    tracked_n;
	logic [COORD_W-1:0] last_x_n;
	logic [COORD_W-1:0] last_y_n;
	logic [SIZE_W-1:0]  last_size_n;
	logic [FPC_W-1:0]   fpc_n;
	point_t             chosen_n;
	logic               match_n;
	logic               frame_up;
	evq_req_t           req_raw;

	function automatic logic [ESIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] c;
		c = (s > SIZE_LIMIT) ? SIZE_LIMIT : s;
		return c[ESIZE_W-1:0];
	endfunction

	function automatic event_t make_event(input kind_t k, input point_t p);
		event_t e;
		e.kind = k;
		e.id   = p.id;
		e.x    = p.x;
		e.y    = p.y;
		e.size = clamp_size(p.size);
		return e;
	endfunction

	// a pop waits for the output register; everything else goes at once
	assign op_take = op_valid && ((op.cmd != CMD_POP) || pop_ready);

	// next tracking state and queue request for the word at the head
	always_comb begin
		pressed_n   = pressed_q;
		tracked_n   = tracked_q;
		last_x_n    = last_x_q;
		last_y_n    = last_y_q;
		last_size_n = last_size_q;
		fpc_n       = fpc_q;
		chosen_n    = chosen_q;
		match_n     = match_q;
		frame_up    = 1'b0;
		req_raw     = '0;
		req_raw.a   = make_event(KIND_UP, '{id: tracked_q, x: last_x_q, y: last_y_q,
			size: last_size_q});
		req_raw.b   = make_event(KIND_DOWN, chosen_q);

		unique case (op.cmd)
			CMD_POINT: begin
				// pick the first point, then the first one matching the tracked id
				if (fpc_q < MAX_FPC) begin
					if (fpc_q == '0) begin
						chosen_n = op.pt;
						match_n  = 1'b0;
					end
					if (pressed_q && !match_n && (op.pt.id == tracked_q)) begin
						chosen_n = op.pt;
						match_n  = 1'b1;
					end
				end
				if (fpc_q <= MAX_FPC) begin
					fpc_n = fpc_q + FPC_W'(1);
				end
				if (op.last) begin
					// close the frame unless it held too many points
					if (fpc_n <= MAX_FPC) begin
						frame_up = pressed_q && !match_n;
						req_raw.b = make_event(KIND_DOWN, chosen_n);
						if (frame_up) begin
							req_raw.a_valid = 1'b1;
							req_raw.b_valid = 1'b1;
						end else if (!pressed_q) begin
							req_raw.a_valid = 1'b1;
							req_raw.a       = make_event(KIND_DOWN, chosen_n);
						end else if ((chosen_n.x != last_x_q) || (chosen_n.y != last_y_q) ||
							(chosen_n.size != last_size_q)) begin
							req_raw.a_valid = 1'b1;
							req_raw.a       = make_event(KIND_MOVE, chosen_n);
						end
						pressed_n   = 1'b1;
						tracked_n   = chosen_n.id;
						last_x_n    = chosen_n.x;
						last_y_n    = chosen_n.y;
						last_size_n = chosen_n.size;
					end
					fpc_n   = '0;
					match_n = 1'b0;
				end
			end
			CMD_EMPTY: begin
				// release the contact with an up event
				fpc_n   = '0;
				match_n = 1'b0;
				if (pressed_q) begin
					req_raw.a_valid = 1'b1;
					pressed_n       = 1'b0;
				end
			end
			CMD_POP: begin
				req_raw.pop = 1'b1;
			end
			CMD_CLEAR: begin
				// drop the frame and release without an event
				fpc_n         = '0;
				match_n       = 1'b0;
				pressed_n     = 1'b0;
				req_raw.clear = 1'b1;
			end
		endcase
	end

	// gate the request with the handshake
	always_comb begin
		req         = req_raw;
		req.a_valid = req_raw.a_valid && op_take;
		req.b_valid = req_raw.b_valid && op_take;
		req.pop     = req_raw.pop && op_take;
		req.clear   = req_raw.clear && op_take;
	end

	// hold tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q   <= 1'b0;
			tracked_q   <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_size_q <= '0;
			fpc_q       <= '0;
			chosen_q    <= '0;
			match_q     <= 1'b0;
		end else if (op_take) begin
			pressed_q   <= pressed_n;
			tracked_q   <= tracked_n;
			last_x_q    <= last_x_n;
			last_y_q    <= last_y_n;
			last_size_q <= last_size_n;
			fpc_q       <= fpc_n;
			chosen_q    <= chosen_n;
			match_q     <= match_n;
		end
	end

endmodule

`default_nettype wire

>>> src/stt_evq.sv
// ----------------------------------------------------------------------------
// stt_evq: event queue and result register of the single touch tracker
// Stores up to two new events a cycle, drops them when full, and pops the
// oldest event into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_evq
	import stt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire evq_req_t      req,
	output logic               pop_ready,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic               event_valid,
	output logic [1:0]         event_kind,
	output logic [ID_W-1:0]    event_id,
	output logic [COORD_W-1:0] event_x,
	output logic [COORD_W-1:0] event_y,
	output logic [ESIZE_W-1:0] event_size,
	output logic [WAIT_W-1:0]  events_waiting
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	event_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               res_valid_q;

	logic               wr0;
	logic               wr1;
	logic [CNT_W-1:0]   cnt_a;
	logic [PTR_W-1:0]   tail_1;
	logic [PTR_W-1:0]   tail_b;
	logic [PTR_W-1:0]   tail_n;
	logic               has_event;
	logic [CNT_W-1:0]   cnt_dec;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// space check for each of the two new events
	assign wr0     = req.a_valid && (cnt_q != DEPTH_C);
	assign cnt_a   = cnt_q + CNT_W'(wr0);
	assign wr1     = req.b_valid && (cnt_a != DEPTH_C);
	assign tail_1  = ptr_inc(tail_q);
	assign tail_b  = wr0 ? tail_1 : tail_q;
	assign tail_n  = wr1 ? ptr_inc(tail_b) : tail_b;

	assign has_event = (cnt_q != '0);
	assign cnt_dec   = cnt_q - CNT_W'(1);

	assign pop_ready    = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;

	// write new events
	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[tail_q] <= req.a;
		end
		if (wr1) begin
			mem_q[tail_b] <= req.b;
		end
	end

	// advance head, tail and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (req.clear) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (req.pop) begin
			if (has_event) begin
				head_q <= ptr_inc(head_q);
				cnt_q  <= cnt_dec;
			end
		end else begin
			tail_q <= tail_n;
			cnt_q  <= cnt_a + CNT_W'(wr1);
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req.pop) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// load the popped event, or zeros on an empty queue
	always_ff @(posedge clk) begin
		if (req.pop) begin
			if (has_event) begin
				event_valid    <= 1'b1;
				event_kind     <= mem_q[head_q].kind;
				event_id       <= mem_q[head_q].id;
				event_x        <= mem_q[head_q].x;
				event_y        <= mem_q[head_q].y;
				event_size     <= mem_q[head_q].size;
				events_waiting <= WAIT_W'(cnt_dec);
			end else begin
				event_valid    <= 1'b0;
				event_kind     <= '0;
				event_id       <= '0;
				event_x        <= '0;
				event_y        <= '0;
				event_size     <= '0;
				events_waiting <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/single_touch_tracker_fifo.sv
// ----------------------------------------------------------------------------
// single_touch_tracker_fifo: single contact tracker with event queue
// Follows one contact across multi-touch frames and queues down, move and
// up events; pop and clear commands read and empty the queue.
//
//   channel   handshake                   payload
//   input     item_valid / item_stall     cmd, point_id, point_x, point_y,
//                                         point_size, last_in_frame
//   result    result_valid / result_stall event_valid, event_kind, event_id,
//                                         event_x, event_y, event_size,
//                                         events_waiting
//
// One word per cycle is accepted unless stalled, tracked unless a pop waits.
// A pop's result is registered in the result register as the tracker takes
// the pop from the input queue; only a pop waits on that register being free.
// The two-entry input queue stalls the input once the back end is held.
// Reset clears tracking state and the queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module single_touch_tracker_fifo
	import stt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [ID_W-1:0]    point_id,
	input  wire logic [COORD_W-1:0] point_x,
	input  wire logic [COORD_W-1:0] point_y,
	input  wire logic [SIZE_W-1:0]  point_size,
	input  wire logic               last_in_frame,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    event_valid,
	output logic [1:0]              event_kind,
	output logic [ID_W-1:0]         event_id,
	output logic [COORD_W-1:0]      event_x,
	output logic [COORD_W-1:0]      event_y,
	output logic [ESIZE_W-1:0]      event_size,
	output logic [WAIT_W-1:0]       events_waiting
);

	logic     op_valid;
	op_t      op;
	logic     op_take;
	logic     pop_ready;
	evq_req_t req;

	// accept and decode
	stt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.point_id      (point_id),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_size    (point_size),
		.last_in_frame (last_in_frame),
		.op_valid      (op_valid),
		.op            (op),
		.op_take       (op_take)
	);

	// track the contact
	stt_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.pop_ready (pop_ready),
		.req       (req)
	);

	// queue events and drive results
	stt_evq u_evq (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.pop_ready      (pop_ready),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.event_valid    (event_valid),
		.event_kind     (event_kind),
		.event_id       (event_id),
		.event_x        (event_x),
		.event_y        (event_y),
		.event_size     (event_size),
		.events_waiting (events_waiting)
	);

endmodule

`default_nettype wire
